FILE: src/idea_block_cipher_macros.svh
// Assertion macros for the IDEA cipher block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef IDEA_BLOCK_CIPHER_MACROS_SVH
`define IDEA_BLOCK_CIPHER_MACROS_SVH

// same-cycle implication, disabled in reset
`define IDEA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idea check failed");

// next-cycle implication, disabled in reset
`define IDEA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("idea check failed");

`endif

FILE: src/idea_pkg.sv
// Shared types, constants and arithmetic for the IDEA cipher block.
// No dependencies.
package idea_pkg;

    localparam int NUM_SUBKEYS = 52;
    localparam int NUM_INV     = 18;
    localparam int NUM_ROUNDS  = 8;
    localparam int KEY_ROT     = 25;
    localparam int IDEA_MOD    = 65537;

    typedef logic [15:0]                   t_word;
    typedef logic [NUM_SUBKEYS-1:0][15:0]  t_subkeys;
    typedef logic [5:0][15:0]              t_rkeys;
    typedef logic [3:0][15:0]              t_okeys;

    typedef struct packed {
        logic  func;
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word s;
    } t_blk;

    // multiply modulo 65537, word 0 stands for 65536
    function automatic t_word mmul(t_word a, t_word b);
        logic [16:0] x;
        logic [16:0] y;
        logic [33:0] p;
        logic [17:0] r;
        x = (a == 16'h0) ? 17'h10000 : {1'b0, a};
        y = (b == 16'h0) ? 17'h10000 : {1'b0, b};
        p = x * y;
        r = {2'b00, p[15:0]} - {1'b0, p[32:16]};
        if (r[17]) begin
            r = r + 18'(IDEA_MOD);
        end
        return r[15:0];
    endfunction

    function automatic t_subkeys enc_keys(logic [127:0] key);
        t_subkeys     ek;
        logic [127:0] rot;
        int           s;
        for (int n = 0; n < NUM_SUBKEYS; n++) begin
            s = (KEY_ROT * (n / 8)) % 128;
            rot = (key << s) | (key >> (128 - s));
            ek[n] = rot[127 - 16 * (n % 8) -: 16];
        end
        return ek;
    endfunction

endpackage

FILE: src/idea_in_if.sv
// Input channel of the IDEA cipher: handshake plus func and block.
// Depends on nothing.
interface idea_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] block_in;

    modport source (output valid, output func, output block_in, input ready);
    modport sink   (input valid, input func, input block_in, output ready);
endinterface

FILE: src/idea_out_if.sv
// Output channel of the IDEA cipher: handshake plus result block.
// Depends on nothing.
interface idea_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_out;

    modport source (output valid, output block_out, input ready);
    modport sink   (input valid, input block_out, output ready);
endinterface

FILE: src/idea_minv.sv
// Iterative inverse modulo 65537: x^65535 by fifteen square-and-multiply steps.
// Uses mmul from idea_pkg; one modular multiply per cycle.
module idea_minv
    import idea_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_operand,
    output t_word o_result,
    output logic  o_done
);

    localparam logic [3:0] LAST_STEP = 4'd14;

    logic       r_run, n_run;
    logic       r_ph, n_ph;
    logic [3:0] r_cnt, n_cnt;
    logic       r_done, n_done;
    t_word      r_acc, n_acc;
    t_word      r_x, n_x;

    always_comb begin
        n_run  = r_run;
        n_ph   = r_ph;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_acc  = r_acc;
        n_x    = r_x;
        if (i_start) begin
            n_run = 1'b1;
            n_ph  = 1'b0;
            n_cnt = 4'd0;
            n_acc = i_operand;
            n_x   = i_operand;
        end else if (r_run) begin
            n_acc = mmul(r_acc, r_ph ? r_x : r_acc);
            n_ph  = ~r_ph;
            if (r_ph) begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == LAST_STEP) begin
                    n_run  = 1'b0;
                    n_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_ph   <= 1'b0;
            r_cnt  <= 4'd0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_ph   <= n_ph;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
    end

    assign o_result = r_acc;
    assign o_done   = r_done;

endmodule

FILE: src/idea_ksched.sv
// Key schedule: encryption subkeys by rotation, decryption subkeys by
// inversion and negation. Depends on idea_pkg, idea_minv and the macro header.
`include "idea_block_cipher_macros.svh"
module idea_ksched
    import idea_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_restart,
    input  logic [127:0] i_key,
    output t_subkeys     o_ek,
    output t_subkeys     o_dk,
    output logic         o_busy
);

    typedef enum logic [2:0] {
        KS_IDLE  = 3'b001,
        KS_START = 3'b010,
        KS_WAIT  = 3'b100
    } t_ks_state;

    localparam logic [4:0] LAST_INV = 5'(NUM_INV - 1);

    t_ks_state                r_state, n_state;
    logic [4:0]               r_j, n_j;
    logic [NUM_INV-1:0][15:0] r_inv;
    t_subkeys                 w_ek;
    t_subkeys                 w_dk;
    t_word                    w_operand;
    t_word                    w_result;
    logic                     w_done;
    logic                     w_start;

    assign w_ek = enc_keys(i_key);

    always_comb begin
        w_operand = 16'h0;
        for (int q = 0; q < NUM_INV; q++) begin
            if (r_j == 5'(q)) begin
                w_operand = w_ek[48 - 6 * (q / 2) + 3 * (q % 2)];
            end
        end
    end

    assign w_start = (r_state == KS_START) && !i_restart;

    idea_minv u_minv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_operand (w_operand),
        .o_result  (w_result),
        .o_done    (w_done)
    );

    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        if (i_restart) begin
            n_state = KS_START;
            n_j     = 5'd0;
        end else begin
            unique case (r_state)
                KS_IDLE:  n_state = KS_IDLE;
                KS_START: n_state = KS_WAIT;
                KS_WAIT: begin
                    if (w_done) begin
                        if (r_j == LAST_INV) begin
                            n_state = KS_IDLE;
                        end else begin
                            n_j     = r_j + 5'd1;
                            n_state = KS_START;
                        end
                    end
                end
                default: n_state = KS_START;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KS_START;
            r_j     <= 5'd0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
        end
        if (r_state == KS_WAIT && w_done) begin
            r_inv[r_j] <= w_result;
        end
    end

    always_comb begin
        for (int r = 0; r <= NUM_ROUNDS; r++) begin
            w_dk[6 * r]     = r_inv[2 * r];
            w_dk[6 * r + 3] = r_inv[2 * r + 1];
            if (r == 0 || r == NUM_ROUNDS) begin
                w_dk[6 * r + 1] = 16'(16'h0 - w_ek[49 - 6 * r]);
                w_dk[6 * r + 2] = 16'(16'h0 - w_ek[50 - 6 * r]);
            end else begin
                w_dk[6 * r + 1] = 16'(16'h0 - w_ek[50 - 6 * r]);
                w_dk[6 * r + 2] = 16'(16'h0 - w_ek[49 - 6 * r]);
            end
            if (r < NUM_ROUNDS) begin
                w_dk[6 * r + 4] = w_ek[46 - 6 * r];
                w_dk[6 * r + 5] = w_ek[47 - 6 * r];
            end
        end
    end

    assign o_ek   = w_ek;
    assign o_dk   = w_dk;
    assign o_busy = (r_state != KS_IDLE);

    `IDEA_ASSERT_NEXT(a_ks_finish, i_clk, i_rst_n,
        r_state == KS_WAIT && w_done && r_j == LAST_INV && !i_restart, !o_busy)

endmodule

FILE: src/idea_round.sv
// One IDEA round over three register stages: key mix, first MA multiply,
// second MA multiply with the xor and swap. Depends on idea_pkg.
module idea_rnd_stage
    import idea_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_blk   i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_blk   o_data,
    input  t_rkeys i_ek,
    input  t_rkeys i_dk
);

    logic [2:0]    r_v;
    t_blk          r_d0, r_d1, r_d2;
    t_blk          n_d0, n_d1, n_d2;
    t_rkeys        w_k0, w_k1, w_k2;
    logic          w_rdy0, w_rdy1, w_rdy2;
    t_word         w_t;
    t_word         w_s2;

    assign w_rdy2 = !r_v[2] || i_ready;
    assign w_rdy1 = !r_v[1] || w_rdy2;
    assign w_rdy0 = !r_v[0] || w_rdy1;

    assign w_k0 = i_data.func ? i_dk : i_ek;
    assign w_k1 = r_d0.func ? i_dk : i_ek;
    assign w_k2 = r_d1.func ? i_dk : i_ek;

    always_comb begin
        n_d0   = i_data;
        n_d0.a = mmul(i_data.a, w_k0[0]);
        n_d0.b = i_data.b + w_k0[1];
        n_d0.c = i_data.c + w_k0[2];
        n_d0.d = mmul(i_data.d, w_k0[3]);

        n_d1   = r_d0;
        n_d1.s = mmul(r_d0.a ^ r_d0.c, w_k1[4]);

        w_t    = mmul(r_d1.s + (r_d1.b ^ r_d1.d), w_k2[5]);
        w_s2   = r_d1.s + w_t;
        n_d2   = r_d1;
        n_d2.a = r_d1.a ^ w_t;
        n_d2.d = r_d1.d ^ w_s2;
        n_d2.b = r_d1.c ^ w_t;
        n_d2.c = r_d1.b ^ w_s2;
        n_d2.s = 16'h0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 3'b000;
        end else begin
            if (w_rdy0) r_v[0] <= i_valid;
            if (w_rdy1) r_v[1] <= r_v[0];
            if (w_rdy2) r_v[2] <= r_v[1];
        end
        if (w_rdy0 && i_valid) r_d0 <= n_d0;
        if (w_rdy1 && r_v[0])  r_d1 <= n_d1;
        if (w_rdy2 && r_v[1])  r_d2 <= n_d2;
    end

    assign o_ready = w_rdy0;
    assign o_valid = r_v[2];
    assign o_data  = r_d2;

endmodule

FILE: src/idea_oxform.sv
// Output transform and result register of the IDEA cipher.
// Depends on idea_pkg.
module idea_oxform
    import idea_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_blk        i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_block,
    input  t_okeys      i_ek,
    input  t_okeys      i_dk
);

    logic        r_v;
    logic [63:0] r_q;
    t_okeys      w_k;
    logic        w_rdy;

    assign w_rdy = !r_v || i_ready;
    assign w_k   = i_data.func ? i_dk : i_ek;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
        if (w_rdy && i_valid) begin
            r_q <= {mmul(i_data.a, w_k[0]), 16'(i_data.c + w_k[1]),
                    16'(i_data.b + w_k[2]), mmul(i_data.d, w_k[3])};
        end
    end

    assign o_ready = w_rdy;
    assign o_valid = r_v;
    assign o_block = r_q;

endmodule

FILE: src/idea_block_cipher.sv
// IDEA cipher top level: an accepted item passes 24 round stages, then the
// output register; one item per cycle unless the output stalls or a key write
// or the key schedule holds the input. Reset clears the key to zero; after
// reset or a key write the decryption schedule runs 18 serial inverses through
// one shared modular multiplier, and no item is taken meanwhile or during a write.
`include "idea_block_cipher_macros.svh"
module idea_block_cipher
    import idea_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    idea_in_if.sink     i_blk,
    idea_out_if.source  o_blk,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0] r_key_hi;
    logic [63:0] r_key_lo;
    logic        w_wr;
    logic        w_busy;
    t_subkeys    w_ek;
    t_subkeys    w_dk;

    t_blk        w_d [NUM_ROUNDS+1];
    logic        w_v [NUM_ROUNDS+1];
    logic        w_r [NUM_ROUNDS+1];

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[3] ? r_key_lo : r_key_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= 64'h0;
            r_key_lo <= 64'h0;
        end else if (w_wr) begin
            if (paddr[3]) r_key_lo <= pwdata;
            else          r_key_hi <= pwdata;
        end
    end

    idea_ksched u_ksched (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_wr),
        .i_key     ({r_key_hi, r_key_lo}),
        .o_ek      (w_ek),
        .o_dk      (w_dk),
        .o_busy    (w_busy)
    );

    assign w_v[0]      = i_blk.valid && !w_busy && !w_wr;
    assign i_blk.ready = w_r[0] && !w_busy && !w_wr;
    assign w_d[0]      = t_blk'({i_blk.func, i_blk.block_in, 16'h0});

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        idea_rnd_stage u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .o_ready (w_r[g]),
            .i_data  (w_d[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_r[g+1]),
            .o_data  (w_d[g+1]),
            .i_ek    (w_ek[6*g+5 : 6*g]),
            .i_dk    (w_dk[6*g+5 : 6*g])
        );
    end

    idea_oxform u_oxform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v[NUM_ROUNDS]),
        .o_ready (w_r[NUM_ROUNDS]),
        .i_data  (w_d[NUM_ROUNDS]),
        .o_valid (o_blk.valid),
        .i_ready (o_blk.ready),
        .o_block (o_blk.block_out),
        .i_ek    (w_ek[51:48]),
        .i_dk    (w_dk[51:48])
    );

    `IDEA_ASSERT_NOW(a_no_take_busy, i_clk, i_rst_n, w_busy, !i_blk.ready)
    `IDEA_ASSERT_NEXT(a_write_busy, i_clk, i_rst_n, w_wr, w_busy)

endmodule
